// ===== src/rofe_pkg.sv =====
// ============================================================================
// rofe_pkg - row outlier event filter shared types and constants
// Word layouts, configuration register set, controller state and the
// command/status bundles between controller and datapath.
// ============================================================================
package rofe_pkg;

    localparam int W_WEIGHT     = 24;
    localparam int W_ETA        = 12;
    localparam int W_CENT       = 10;
    localparam int W_CNT        = 7;
    localparam int W_SUM        = 30;
    localparam int W_SQ         = 54;
    localparam int W_TOTAL      = 36;
    localparam int W_RUN        = 3;
    localparam int W_CFG_IDX    = 3;
    localparam int W_CFG_DATA   = 36;
    localparam int MAX_ROW_BINS = 64;

    // derived datapath widths for the row-end test
    localparam int W_TOP    = W_CNT + W_WEIGHT;   // n * peak
    localparam int W_SPREAD = W_CNT + W_SQ;       // n * sumsq
    localparam int W_SUM2   = 2 * W_SUM;          // sum^2
    localparam int W_LEAD2  = 2 * W_TOP;          // lead^2
    localparam int W_S2     = 8;                  // sigma^2
    localparam int W_SVAR   = W_S2 + W_SPREAD;    // sigma^2 * var

    localparam logic [W_RUN-1:0] RUN_MAX = 3'd7;

    // configuration register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_SIMULATED_DATA    = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_FORWARD_ETA_LIMIT = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_CENTRALITY_LIMIT  = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_SIGMA_LIMIT       = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_MAX_BAD_RUN       = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_MIN_TOTAL         = 3'd5;

    typedef struct packed {
        logic [W_WEIGHT-1:0]     weight;
        logic signed [W_ETA-1:0] eta;
        logic                    last_in_row;
        logic                    last_in_event;
        logic [W_CENT-1:0]       centrality;
    } t_in_word;

    typedef struct packed {
        logic keep_event;
        logic edge_empty;
        logic outlier_run;
        logic low_total;
    } t_out_word;

    typedef struct packed {
        logic               simulated_data;
        logic [10:0]        forward_eta_limit;
        logic [W_CENT-1:0]  centrality_limit;
        logic [3:0]         sigma_limit;
        logic [W_RUN-1:0]   max_bad_run;
        logic [W_TOTAL-1:0] min_total;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_SQR,
        S_TEST,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic acc;    // take a bin into the row/event accumulators
        logic mul;    // row end: products
        logic sub;    // row end: differences and qualifiers
        logic sqr;    // row end: squares for the threshold compare
        logic test;   // row end: decide, update run, clear row
        logic emit;   // load result word, clear event
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== src/row_outlier_event_filter_unit.sv =====
// ============================================================================
// row_outlier_event_filter_unit - per-event outlier row filter
// Bins of one event's histogram stream in row by row. A bin that does not end
// a row is taken without a stall. After a bin that ends a row (or the event),
// stall is held while the row-end test walks its stages: products n*peak,
// n*sumsq and sum^2, then differences, then lead^2 and sigma^2*var, then the
// compare and bad-row run update. After an event-end bin the result word is
// loaded, later if the previous word is not yet taken. The result register
// lets the next event's bins in while a word waits. The user must write the
// configuration through the plain write port only while idle (not enforced).
// ============================================================================
module row_outlier_event_filter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rofe_pkg::W_CFG_IDX-1:0]   i_cfg_idx,
    input  logic [rofe_pkg::W_CFG_DATA-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  rofe_pkg::t_in_word               i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output rofe_pkg::t_out_word              o_data
);
    import rofe_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    rofe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rofe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_row_end (i_data.last_in_row),
        .i_ev_end  (i_data.last_in_event),
        .o_stall   (o_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    rofe_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_data  (i_data),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== src/rofe_cfg.sv =====
// ============================================================================
// rofe_cfg - configuration registers
// Plain write port; writes to an unused index are ignored.
// ============================================================================
module rofe_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rofe_pkg::W_CFG_IDX-1:0]   i_cfg_idx,
    input  logic [rofe_pkg::W_CFG_DATA-1:0]  i_cfg_data,
    output rofe_pkg::t_cfg                   o_cfg
);
    import rofe_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIMULATED_DATA:    n_cfg.simulated_data    = i_cfg_data[0];
                CFG_FORWARD_ETA_LIMIT: n_cfg.forward_eta_limit = i_cfg_data[10:0];
                CFG_CENTRALITY_LIMIT:  n_cfg.centrality_limit  = i_cfg_data[W_CENT-1:0];
                CFG_SIGMA_LIMIT:       n_cfg.sigma_limit       = i_cfg_data[3:0];
                CFG_MAX_BAD_RUN:       n_cfg.max_bad_run       = i_cfg_data[W_RUN-1:0];
                CFG_MIN_TOTAL:         n_cfg.min_total         = i_cfg_data[W_TOTAL-1:0];
                default:               n_cfg                   = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.simulated_data    <= 1'b0;
            r_cfg.forward_eta_limit <= 11'd435;
            r_cfg.centrality_limit  <= 10'd600;
            r_cfg.sigma_limit       <= 4'd4;
            r_cfg.max_bad_run       <= 3'd3;
            r_cfg.min_total         <= 36'd2560;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/rofe_ctrl.sv =====
// ============================================================================
// rofe_ctrl - sequencer
// Accepts bins, walks the four row-end stages and hands out the result word.
// ============================================================================
module rofe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_row_end,
    input  logic           i_ev_end,
    output logic           o_stall,
    input  rofe_pkg::t_sts i_sts,
    output rofe_pkg::t_cmd o_cmd
);
    import rofe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_ev_end;
    logic   n_ev_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ev_end <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_end <= n_ev_end;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ev_end = r_ev_end;
        o_cmd    = '0;
        o_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    n_ev_end  = i_ev_end;
                    // an event end closes the open row as well
                    if (i_row_end || i_ev_end) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_SQR;
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = r_ev_end ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rofe_dp.sv =====
// ============================================================================
// rofe_dp - accumulators, row-end test pipeline and result register
// Row statistics, event total and flags, plus the output word register.
// ============================================================================
module rofe_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rofe_pkg::t_cfg     i_cfg,
    input  rofe_pkg::t_cmd     i_cmd,
    input  rofe_pkg::t_in_word i_data,
    output rofe_pkg::t_sts     o_sts,
    output logic               o_valid,
    input  logic               i_stall,
    output rofe_pkg::t_out_word o_data
);
    import rofe_pkg::*;

    // row and event state
    logic [W_SUM-1:0]    r_sum;
    logic [W_SQ-1:0]     r_sq;
    logic [W_WEIGHT-1:0] r_peak;
    logic [W_CNT-1:0]    r_cnt;
    logic [W_TOTAL-1:0]  r_total;
    logic [W_RUN-1:0]    r_run;
    logic                r_edge;
    logic                r_run_flag;
    logic                r_cent_ok;

    // row-end pipeline
    logic [W_TOP-1:0]    r_top;
    logic [W_SPREAD-1:0] r_spread;
    logic [W_SUM2-1:0]   r_sum2;
    logic [W_SPREAD-1:0] r_var;
    logic [W_TOP-1:0]    r_lead;
    logic [W_S2-1:0]     r_s2;
    logic                r_ok;
    logic [W_LEAD2-1:0]  r_lead2;
    logic [W_SVAR-1:0]   r_svar;
    logic                r_ok2;

    // output register
    logic                r_out_valid;
    t_out_word           r_out;

    logic [W_ETA:0]      eta_abs;
    logic [W_TOTAL:0]    total_add;
    logic [2*W_WEIGHT-1:0] w_sq;
    logic                bad;
    logic [W_RUN-1:0]    n_run;
    logic                low;
    logic                edge_hit;

    assign eta_abs = i_data.eta[W_ETA-1]
                   ? ((W_ETA+1)'(1 << W_ETA) - {1'b0, i_data.eta})
                   : {1'b0, i_data.eta};
    assign edge_hit = (r_cnt == '0) && !i_cfg.simulated_data
                   && (eta_abs > (W_ETA+1)'(i_cfg.forward_eta_limit))
                   && (i_data.weight == '0);
    assign total_add = {1'b0, r_total} + (W_TOTAL+1)'(i_data.weight);
    assign w_sq      = i_data.weight * i_data.weight;

    // lead^2 >= sigma^2 * var, exact
    assign bad = r_ok2 && ((W_SVAR)'(r_lead2) >= r_svar);

    always_comb begin
        if (bad) begin
            n_run = (r_run < RUN_MAX) ? r_run + 1'b1 : r_run;
        end else begin
            n_run = '0;
        end
    end

    assign low = r_total < i_cfg.min_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_sq       <= '0;
            r_peak     <= '0;
            r_cnt      <= '0;
            r_total    <= '0;
            r_run      <= '0;
            r_edge     <= 1'b0;
            r_run_flag <= 1'b0;
        end else if (i_cmd.acc) begin
            if (edge_hit) begin
                r_edge <= 1'b1;
            end
            r_total <= total_add[W_TOTAL] ? '1 : total_add[W_TOTAL-1:0];
            // bins past the row limit only reach the event total
            if (r_cnt < W_CNT'(MAX_ROW_BINS)) begin
                r_sum <= r_sum + W_SUM'(i_data.weight);
                r_sq  <= r_sq + W_SQ'(w_sq);
                if (i_data.weight > r_peak) begin
                    r_peak <= i_data.weight;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.test) begin
            r_run <= n_run;
            if (n_run > i_cfg.max_bad_run) begin
                r_run_flag <= 1'b1;
            end
            r_sum  <= '0;
            r_sq   <= '0;
            r_peak <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.emit) begin
            r_total    <= '0;
            r_run      <= '0;
            r_edge     <= 1'b0;
            r_run_flag <= 1'b0;
        end
    end

    // row-end pipeline, one product or difference stage per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_cent_ok <= i_data.centrality < i_cfg.centrality_limit;
        end
        if (i_cmd.mul) begin
            r_top    <= W_TOP'(r_cnt) * W_TOP'(r_peak);
            r_spread <= W_SPREAD'(r_cnt) * W_SPREAD'(r_sq);
            r_sum2   <= W_SUM2'(r_sum) * W_SUM2'(r_sum);
        end
        if (i_cmd.sub) begin
            r_var  <= r_spread - W_SPREAD'(r_sum2);
            r_lead <= r_top - W_TOP'(r_sum);
            r_s2   <= W_S2'(i_cfg.sigma_limit) * W_S2'(i_cfg.sigma_limit);
            r_ok   <= (i_cfg.sigma_limit != '0) && r_cent_ok && (r_cnt != '0)
                   && (r_spread > W_SPREAD'(r_sum2)) && (r_top >= W_TOP'(r_sum));
        end
        if (i_cmd.sqr) begin
            r_lead2 <= W_LEAD2'(r_lead) * W_LEAD2'(r_lead);
            r_svar  <= W_SVAR'(r_s2) * W_SVAR'(r_var);
            r_ok2   <= r_ok;
        end
    end

    // result register; frees up when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.keep_event  <= !r_edge && !r_run_flag && !low;
            r_out.edge_empty  <= r_edge;
            r_out.outlier_run <= r_run_flag;
            r_out.low_total   <= low;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_data         = r_out;

endmodule

// ===== tb/row_outlier_event_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// row_outlier_event_filter_unit_tb - self-checking bench for the event filter
// Streams histogram bins row by row and predicts each event verdict from its
// own model of the row statistics, outlier test, bad-row run and event total.
// Covers register extremes, forward empty edges, overlong rows, random
// back-pressure and a long receiver hold-off.
// ============================================================================
module row_outlier_event_filter_unit_tb;
    import rofe_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SINK_HOLD_LEN  = 400;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_BINS    = 1150;
    localparam int PHASE_BINS     = 160;

    localparam logic [W_TOTAL-1:0] TOTAL_SAT = '1;

    localparam t_cfg RESET_CFG    = '{1'b0, 11'd435, 10'd600, 4'd4, 3'd3, 36'd2560};
    localparam t_cfg DIRECTED_CFG = '{1'b0, 11'd435, 10'd600, 4'd1, 3'd1, 36'd2560};
    localparam t_cfg SIMDATA_CFG  = '{1'b1, 11'd435, 10'd600, 4'd1, 3'd1, 36'd2560};
    localparam t_cfg LOW_CFG      = '{1'b0, 11'd0, 10'd0, 4'd0, 3'd0, 36'd0};
    localparam t_cfg HIGH_CFG     = '{1'b1, 11'd2047, 10'd1023, 4'd15, 3'd7, TOTAL_SAT};

    typedef enum int {
        ROW_FLAT,
        ROW_SPIKE,
        ROW_NOISE,
        ROW_EDGE_GAP,
        ROW_ZERO
    } t_row_kind;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [W_CFG_IDX-1:0]  i_cfg_idx  = '0;
    logic [W_CFG_DATA-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in_word              i_data     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out_word             o_data;

    row_outlier_event_filter_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    always #10 i_clk = ~i_clk;

    // filter model: configuration and per-row / per-event accumulators
    t_cfg             cfg_m;
    logic [63:0]      row_sum_m;
    logic [63:0]      row_sq_m;
    logic [63:0]      row_peak_m;
    logic [W_CNT-1:0] row_bins_m;
    logic [W_RUN-1:0] bad_rows_m;
    logic [W_TOTAL-1:0] total_m;
    logic             edge_m;
    logic             run_m;
    t_out_word        verdict_q[$];

    bit src_idle   = 1'b1;
    bit snk_idle   = 1'b1;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int bins_sent  = 0;
    int err_cnt    = 0;

    function automatic void clear_row_acc();
        row_sum_m  = '0;
        row_sq_m   = '0;
        row_peak_m = '0;
        row_bins_m = '0;
    endfunction

    function automatic void clear_event_acc();
        clear_row_acc();
        bad_rows_m = '0;
        total_m    = '0;
        edge_m     = 1'b0;
        run_m      = 1'b0;
    endfunction

    function automatic void close_row_acc(input logic [W_CENT-1:0] cent);
        logic [63:0] n;
        logic [63:0] top;
        logic [63:0] spread;
        logic [63:0] sum2;
        logic [63:0] var_t;
        logic [63:0] lead;
        logic [63:0] s2;
        logic        bad;
        n      = 64'(row_bins_m);
        top    = n * row_peak_m;
        spread = n * row_sq_m;
        sum2   = row_sum_m * row_sum_m;
        bad    = 1'b0;
        if (cfg_m.sigma_limit != 0 && cent < cfg_m.centrality_limit && n > 0 &&
            spread > sum2 && top >= row_sum_m) begin
            var_t = spread - sum2;
            lead  = top - row_sum_m;
            s2    = 64'(cfg_m.sigma_limit) * 64'(cfg_m.sigma_limit);
            // floor(lead^2 / s^2) >= var is the exact form of lead^2 >= s^2 * var
            bad   = (lead * lead) / s2 >= var_t;
        end
        if (bad) begin
            if (bad_rows_m < RUN_MAX)
                bad_rows_m = bad_rows_m + 1'b1;
        end else begin
            bad_rows_m = '0;
        end
        if (bad_rows_m > cfg_m.max_bad_run)
            run_m = 1'b1;
        clear_row_acc();
    endfunction

    function automatic void filter_bin(input t_in_word b);
        logic [W_ETA:0]     eta_mag;
        logic [W_TOTAL:0]   tot;
        logic               below_min;
        t_out_word          v;
        eta_mag = b.eta[W_ETA-1] ? (13'h1000 - {1'b0, b.eta}) : {1'b0, b.eta};
        if (row_bins_m == 0 && !cfg_m.simulated_data &&
            eta_mag > cfg_m.forward_eta_limit && b.weight == 0)
            edge_m = 1'b1;
        tot = (W_TOTAL+1)'(total_m) + (W_TOTAL+1)'(b.weight);
        total_m = (tot > TOTAL_SAT) ? TOTAL_SAT : tot[W_TOTAL-1:0];
        // bins past the row limit only feed the event total
        if (row_bins_m < MAX_ROW_BINS) begin
            row_sum_m = row_sum_m + 64'(b.weight);
            row_sq_m  = row_sq_m + 64'(b.weight) * 64'(b.weight);
            if (b.weight > row_peak_m)
                row_peak_m = 64'(b.weight);
            row_bins_m = row_bins_m + 1'b1;
        end
        if (b.last_in_row || b.last_in_event)
            close_row_acc(b.centrality);
        if (b.last_in_event) begin
            below_min     = total_m < cfg_m.min_total;
            v.keep_event  = !edge_m && !run_m && !below_min;
            v.edge_empty  = edge_m;
            v.outlier_run = run_m;
            v.low_total   = below_min;
            verdict_q.push_back(v);
            clear_event_acc();
        end
    endfunction

    function automatic t_in_word mk_bin(input logic [W_WEIGHT-1:0] w,
                                        input logic [W_ETA-1:0] eta,
                                        input bit row_end, input bit ev_end,
                                        input logic [W_CENT-1:0] cent);
        t_in_word b;
        b.weight        = w;
        b.eta           = eta;
        b.last_in_row   = row_end;
        b.last_in_event = ev_end;
        b.centrality    = cent;
        return b;
    endfunction

    function automatic logic [W_WEIGHT-1:0] rand_weight();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return W_WEIGHT'($urandom_range(0, 255));
            2:       return W_WEIGHT'($urandom_range(0, 65535));
            default: return W_WEIGHT'($urandom);
        endcase
    endfunction

    function automatic logic [W_ETA-1:0] rand_eta();
        logic [W_ETA-1:0] e;
        int               mag;
        case ($urandom_range(0, 3))
            0: e = W_ETA'($urandom_range(0, 4095));
            1: begin
                // just around the forward boundary, either sign
                mag = int'(cfg_m.forward_eta_limit) + $urandom_range(0, 2) - 1;
                if (mag < 0)
                    mag = 0;
                e = mag[W_ETA-1:0];
                if ($urandom_range(0, 1))
                    e = -e;
            end
            2: begin
                e = W_ETA'($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                    e = -e;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       e = 12'h800;
                    1:       e = 12'h7FF;
                    2:       e = 12'hC00;
                    default: e = 12'd1536;
                endcase
            end
        endcase
        return e;
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.simulated_data = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0:       c.forward_eta_limit = 11'd0;
            1:       c.forward_eta_limit = 11'd2047;
            2:       c.forward_eta_limit = 11'($urandom_range(256, 1536));
            default: c.forward_eta_limit = 11'd435;
        endcase
        c.centrality_limit = ($urandom_range(0, 5) == 0) ? W_CENT'($urandom_range(0, 1023))
                                                         : W_CENT'($urandom_range(600, 1023));
        c.sigma_limit = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 3));
        c.max_bad_run = W_RUN'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       c.min_total = '0;
            1:       c.min_total = W_TOTAL'({$urandom, $urandom});
            default: c.min_total = W_TOTAL'($urandom_range(0, 40000));
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [3:0] got,
                                   input logic [3:0] want);
        err_cnt++;
        $display("%0t ns: mismatch on %s: got %b, want %b", $time, what, got, want);
    endtask

    task automatic send_bin(input t_in_word b);
        if (src_idle) begin
            while ($urandom_range(0, 99) < 34) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        filter_bin(b);
        bins_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_row(input logic [W_ETA-1:0] eta, input int nbins,
                            input t_row_kind kind, input logic [W_CENT-1:0] cent,
                            input bit per_bin_cent, input bit ends_event,
                            input bit closes_row);
        logic [W_WEIGHT-1:0] base;
        logic [W_WEIGHT-1:0] peak;
        int                  spot;
        t_in_word            b;
        base = W_WEIGHT'($urandom_range(0, 4095));
        if ($urandom_range(0, 1))
            peak = base + W_WEIGHT'($urandom_range(1, 4095));
        else
            peak = W_WEIGHT'($urandom_range(int'(base) + 1, 24'hFFFFFF));
        spot = $urandom_range(0, nbins - 1);
        for (int i = 0; i < nbins; i++) begin
            case (kind)
                ROW_FLAT:     b.weight = base;
                ROW_SPIKE:    b.weight = (i == spot) ? peak : base;
                ROW_NOISE:    b.weight = rand_weight();
                ROW_EDGE_GAP: b.weight = (i == 0) ? '0 : rand_weight();
                default:      b.weight = '0;
            endcase
            b.eta           = eta;
            b.centrality    = per_bin_cent ? W_CENT'($urandom_range(0, 1023)) : cent;
            b.last_in_row   = (i == nbins - 1) && closes_row;
            b.last_in_event = (i == nbins - 1) && ends_event;
            send_bin(b);
        end
    endtask

    task automatic send_event(input int nrows);
        logic [W_CENT-1:0] cent;
        bit                per_bin;
        bit                spiky;
        bit                tail_open;
        t_row_kind         kind;
        int                len;
        int                s2;
        int                hi;
        s2 = int'(cfg_m.sigma_limit) * int'(cfg_m.sigma_limit);
        if ($urandom_range(0, 3) == 0 || cfg_m.centrality_limit == 0)
            cent = W_CENT'($urandom_range(0, 1023));
        else
            cent = W_CENT'($urandom_range(0, int'(cfg_m.centrality_limit) - 1));
        per_bin   = ($urandom_range(0, 7) == 0);
        spiky     = ($urandom_range(0, 1) == 1);
        tail_open = ($urandom_range(0, 5) == 0);
        for (int r = 0; r < nrows; r++) begin
            if (spiky && $urandom_range(0, 4) != 0)
                kind = ROW_SPIKE;
            else
                kind = t_row_kind'($urandom_range(0, 4));
            hi = (s2 + 6 > MAX_ROW_BINS) ? MAX_ROW_BINS : s2 + 6;
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(MAX_ROW_BINS + 1, MAX_ROW_BINS + 16);
            else if (kind == ROW_SPIKE && s2 < MAX_ROW_BINS && $urandom_range(0, 1))
                len = $urandom_range(s2 + 1, hi);
            else
                len = $urandom_range(1, 12);
            // an open tail leaves the event end to close the last row
            send_row(rand_eta(), len, kind, cent, per_bin, r == nrows - 1,
                     !(r == nrows - 1 && tail_open));
        end
    endtask

    // sender halts until every verdict is in, then lets the row-end test finish
    task automatic settle();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx,
                             input logic [W_CFG_DATA-1:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        settle();
        write_reg(CFG_SIMULATED_DATA, W_CFG_DATA'(c.simulated_data));
        write_reg(CFG_FORWARD_ETA_LIMIT, W_CFG_DATA'(c.forward_eta_limit));
        write_reg(CFG_CENTRALITY_LIMIT, W_CFG_DATA'(c.centrality_limit));
        write_reg(CFG_SIGMA_LIMIT, W_CFG_DATA'(c.sigma_limit));
        write_reg(CFG_MAX_BAD_RUN, W_CFG_DATA'(c.max_bad_run));
        write_reg(CFG_MIN_TOTAL, W_CFG_DATA'(c.min_total));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        cfg_m = c;
    endtask

    task automatic set_idling(input bit src, input bit snk);
        i_valid <= 1'b0;
        @(posedge i_clk);
        src_idle = src;
        snk_idle = snk;
        @(negedge i_clk);
    endtask

    task automatic hold_sink();
        i_valid <= 1'b0;
        @(posedge i_clk);
        hold_token++;
        @(negedge i_clk);
    endtask

    task automatic test_reset_values();
        repeat (3) send_event($urandom_range(1, 3));
        settle();
    endtask

    task automatic test_directed();
        apply_config(DIRECTED_CFG);
        send_bin(mk_bin(24'hFFFFFF, 12'h000, 1'b1, 1'b1, 10'd0));
        // forward rows opening on an empty bin, both signs, full negative scale
        send_bin(mk_bin(24'd0, 12'd1536, 1'b0, 1'b0, 10'd0));
        send_bin(mk_bin(24'd5000, 12'd1536, 1'b1, 1'b1, 10'd0));
        send_bin(mk_bin(24'd0, 12'h800, 1'b0, 1'b0, 10'd1023));
        send_bin(mk_bin(24'd5000, 12'h800, 1'b1, 1'b1, 10'd1023));
        send_bin(mk_bin(24'd0, 12'h000, 1'b1, 1'b1, 10'd0));
        // three spike rows: run goes past a limit of one
        for (int r = 0; r < 3; r++) begin
            send_bin(mk_bin(24'd0, 12'h000, 1'b0, 1'b0, 10'd0));
            send_bin(mk_bin(24'h010000, 12'h000, 1'b1, r == 2, 10'd0));
        end
        // second spike row is closed by the event end alone
        send_bin(mk_bin(24'd0, 12'h000, 1'b0, 1'b0, 10'd5));
        send_bin(mk_bin(24'd40000, 12'h000, 1'b1, 1'b0, 10'd5));
        send_bin(mk_bin(24'd0, 12'h000, 1'b0, 1'b0, 10'd5));
        send_bin(mk_bin(24'd40000, 12'h000, 1'b0, 1'b1, 10'd5));
        // centrality at the limit: no outlier test
        for (int r = 0; r < 2; r++) begin
            send_bin(mk_bin(24'd0, 12'h000, 1'b0, 1'b0, 10'd600));
            send_bin(mk_bin(24'd40000, 12'h000, 1'b1, r == 1, 10'd600));
        end
        apply_config(SIMDATA_CFG);
        send_bin(mk_bin(24'd0, 12'hA00, 1'b0, 1'b0, 10'd0));
        send_bin(mk_bin(24'd9000, 12'hA00, 1'b1, 1'b1, 10'd0));
        settle();
    endtask

    task automatic test_backpressure();
        apply_config(RESET_CFG);
        set_idling(1'b0, 1'b0);
        hold_sink();
        repeat (4) send_event($urandom_range(1, 2));
        settle();
        set_idling(1'b1, 1'b1);
    endtask

    task automatic test_random();
        int goal;
        int phase;
        int phase_end;
        goal  = bins_sent + RANDOM_BINS;
        phase = 0;
        while (bins_sent < goal) begin
            case (phase)
                0:       apply_config(LOW_CFG);
                1:       apply_config(HIGH_CFG);
                default: apply_config(rand_cfg());
            endcase
            if (phase == 3)
                set_idling(1'b0, 1'b0);
            else
                set_idling(1'b1, 1'b1);
            phase_end = bins_sent + PHASE_BINS;
            while (bins_sent < phase_end && bins_sent < goal)
                send_event($urandom_range(1, 5));
            phase++;
        end
        settle();
    endtask

    // receiver: random stall, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= SINK_HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= snk_idle && ($urandom_range(0, 99) < 34);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("word with no verdict pending", o_data, 4'b0);
            end else begin
                want = verdict_q.pop_front();
                if (o_data.keep_event !== want.keep_event)
                    report_mismatch("keep_event", 4'(o_data.keep_event),
                                    4'(want.keep_event));
                if (o_data.edge_empty !== want.edge_empty)
                    report_mismatch("edge_empty", 4'(o_data.edge_empty),
                                    4'(want.edge_empty));
                if (o_data.outlier_run !== want.outlier_run)
                    report_mismatch("outlier_run", 4'(o_data.outlier_run),
                                    4'(want.outlier_run));
                if (o_data.low_total !== want.low_total)
                    report_mismatch("low_total", 4'(o_data.low_total),
                                    4'(want.low_total));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int guard;
        cfg_m = RESET_CFG;
        clear_event_acc();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed();
        test_backpressure();
        test_random();

        i_valid <= 1'b0;
        guard = 0;
        while (verdict_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch("verdicts never delivered", 4'(verdict_q.size()), 4'b0);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
